// ===== rtl/core/ttcr_pkg.sv =====
package ttcr_pkg;

    localparam int DATA_W    = 16;
    localparam int CNT_W     = 5;
    localparam int SEG_W     = 5;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int QUO_W     = 16;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    localparam logic [DATA_W-1:0]    NO_CODE       = 16'hFFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_COUNT = 2'd1;

    typedef enum logic [1:0] {
        OP_WR_OLD  = 2'd0,
        OP_WR_NEW  = 2'd1,
        OP_CONVERT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_OLD = 2'd1,
        ST_NO_NEW = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic wr_old;
        logic wr_new;
        logic capture;
        logic scan_start;
        logic rd;
        logic mul;
        logic div_init;
        logic div_step;
        logic fin;
        logic miss;
        logic load_out;
        logic sel_new;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic div_last;
    } t_sts;

endpackage

// ===== rtl/core/ttcr_ctrl.sv =====
module ttcr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_op,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ttcr_pkg::t_cmd   o_cmd,
    input  ttcr_pkg::t_sts   i_sts
);
    import ttcr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_second;
    logic   n_second;
    logic   r_out_valid;
    logic   w_take;
    logic   w_conv;
    logic   w_out_free;

    assign w_take     = i_in_valid && (r_state == S_IDLE);
    assign w_conv     = (t_op'(i_op) == OP_CONVERT);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        case (r_state)
            S_IDLE: begin
                if (w_take && w_conv) begin
                    n_state  = S_SCAN;
                    n_second = 1'b0;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = S_MUL;
                end else if (i_sts.scan_end) begin
                    n_state = S_OUT;
                end
            end
            S_MUL:   n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_second) begin
                    n_second = 1'b1;
                    n_state  = S_SCAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.sel_new = r_second;
        case (r_state)
            S_IDLE: begin
                o_cmd.wr_old     = w_take && (t_op'(i_op) == OP_WR_OLD);
                o_cmd.wr_new     = w_take && (t_op'(i_op) == OP_WR_NEW);
                o_cmd.capture    = w_take && w_conv;
                o_cmd.scan_start = w_take && w_conv;
            end
            S_SCAN: begin
                o_cmd.rd   = !i_sts.hit && !i_sts.scan_end;
                o_cmd.miss = !i_sts.hit && i_sts.scan_end;
            end
            S_MUL:   o_cmd.mul      = 1'b1;
            S_DINIT: o_cmd.div_init = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_FIN: begin
                o_cmd.fin        = 1'b1;
                o_cmd.scan_start = !r_second;
            end
            S_OUT:   o_cmd.load_out = w_out_free;
            default: o_cmd.sel_new  = r_second;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output load");

    a_convert_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && w_conv) |=> (r_state == S_SCAN) && !r_second)
        else $error("convert transaction did not start old table scan");

    a_div_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_FIN))
        else $error("division did not finish");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_out_ready) |=> (r_state == S_OUT))
        else $error("result overwritten while receiver stalled");
`endif

endmodule

// ===== rtl/core/ttcr_dpath.sv =====
module ttcr_dpath #(
    parameter int MAX_POINTS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ttcr_pkg::t_cmd                        i_cmd,
    output ttcr_pkg::t_sts                        o_sts,
    input  logic                                  i_cfg_valid,
    input  logic [ttcr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ttcr_pkg::CNT_W-1:0]            i_cfg_data,
    input  logic [ttcr_pkg::IDX_W-1:0]            i_point_index,
    input  logic [ttcr_pkg::DATA_W-1:0]           i_point_code,
    input  logic [ttcr_pkg::DATA_W-1:0]           i_point_value,
    input  logic [ttcr_pkg::DATA_W-1:0]           i_reading,
    output logic [1:0]                            o_status,
    output logic [ttcr_pkg::DATA_W-1:0]           o_code_out,
    output logic [ttcr_pkg::DATA_W-1:0]           o_value_out,
    output logic [ttcr_pkg::SEG_W-1:0]            o_segment_end
);
    import ttcr_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int PW    = $clog2(MAX_POINTS + 1);
    localparam int CMPW  = (PW > CNT_W) ? PW : CNT_W;
    localparam int ENT_W = 2 * DATA_W;
    localparam int DVD_W = 2 * DATA_W + 2;

    logic [ENT_W-1:0]   r_old_mem [MAX_POINTS];
    logic [ENT_W-1:0]   r_new_mem [MAX_POINTS];
    logic [ENT_W-1:0]   r_cur;
    logic [ENT_W-1:0]   r_prev;
    logic [AW-1:0]      r_seg;
    logic [PW-1:0]      r_ptr;
    logic               r_pair;
    logic [CNT_W-1:0]   r_old_cnt;
    logic [CNT_W-1:0]   r_new_cnt;
    logic [DATA_W-1:0]  r_reading;

    logic [ENT_W-1:0]   r_prod;
    logic [DATA_W-1:0]  r_den;
    logic [DATA_W-1:0]  r_y0;
    logic               r_neg;
    logic               r_zero_run;
    logic [DATA_W:0]    r_rem;
    logic [QUO_W-1:0]   r_dq;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [DATA_W-1:0]  r_code;
    logic [DATA_W-1:0]  r_last;
    t_status            r_st;
    logic [SEG_W-1:0]   r_seg_res;
    t_status            r_o_status;
    logic [DATA_W-1:0]  r_o_code;
    logic [DATA_W-1:0]  r_o_value;
    logic [SEG_W-1:0]   r_o_seg;

    logic               w_idx_ok;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_raddr;
    logic [CNT_W-1:0]   w_cnt;
    logic [CMPW-1:0]    w_cnt_x;
    logic [CMPW-1:0]    w_max;
    logic [CMPW-1:0]    w_n;
    logic [DATA_W-1:0]  w_ax;
    logic [DATA_W-1:0]  w_bx;
    logic [DATA_W-1:0]  w_ay;
    logic [DATA_W-1:0]  w_by;
    logic [DATA_W-1:0]  w_key;
    logic [DATA_W-1:0]  w_dx;
    logic [DATA_W-1:0]  w_dy;
    logic [DATA_W-1:0]  w_den;
    logic               w_neg;
    logic [DVD_W-1:0]   w_dvd;
    logic [DATA_W:0]    w_dv;
    logic [DATA_W+1:0]  w_trial;
    logic [DATA_W+1:0]  w_diff;
    logic               w_ge;
    logic [DATA_W:0]    w_sum;
    logic [DATA_W:0]    w_dif;
    logic [DATA_W-1:0]  w_res;

    // table writes and registered reads
    assign w_idx_ok = (32'(i_point_index) < 32'(MAX_POINTS));
    assign w_waddr  = AW'(i_point_index);
    assign w_raddr  = r_ptr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_old && w_idx_ok) begin
            r_old_mem[w_waddr] <= {i_point_code, i_point_value};
        end
        if (i_cmd.wr_new && w_idx_ok) begin
            r_new_mem[w_waddr] <= {i_point_code, i_point_value};
        end
        if (i_cmd.rd) begin
            r_cur  <= i_cmd.sel_new ? r_new_mem[w_raddr] : r_old_mem[w_raddr];
            r_prev <= r_cur;
            r_seg  <= w_raddr;
        end
    end

    // segment scan
    assign w_cnt   = i_cmd.sel_new ? r_new_cnt : r_old_cnt;
    assign w_cnt_x = CMPW'(w_cnt);
    assign w_max   = CMPW'(MAX_POINTS);
    assign w_n     = (w_cnt_x > w_max) ? w_max : w_cnt_x;

    assign w_ax  = i_cmd.sel_new ? r_prev[ENT_W-1:DATA_W] : r_prev[DATA_W-1:0];
    assign w_bx  = i_cmd.sel_new ? r_cur[ENT_W-1:DATA_W]  : r_cur[DATA_W-1:0];
    assign w_ay  = i_cmd.sel_new ? r_prev[DATA_W-1:0]     : r_prev[ENT_W-1:DATA_W];
    assign w_by  = i_cmd.sel_new ? r_cur[DATA_W-1:0]      : r_cur[ENT_W-1:DATA_W];
    assign w_key = i_cmd.sel_new ? r_code : r_reading;

    assign o_sts.hit      = r_pair && (((w_ax >= w_key) && (w_key >= w_bx)) ||
                                       ((w_bx >= w_key) && (w_key >= w_ax)));
    assign o_sts.scan_end = (CMPW'(r_ptr) == w_n);
    assign o_sts.div_last = (r_div_cnt == DIV_CNT_W'(QUO_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_pair    <= 1'b0;
            r_old_cnt <= CNT_W'(2);
            r_new_cnt <= CNT_W'(2);
        end else begin
            if (i_cmd.scan_start) begin
                r_ptr  <= '0;
                r_pair <= 1'b0;
            end else if (i_cmd.rd) begin
                r_ptr  <= r_ptr + PW'(1);
                r_pair <= (r_ptr != '0);
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OLD_COUNT: r_old_cnt <= i_cfg_data;
                    CFG_NEW_COUNT: r_new_cnt <= i_cfg_data;
                    default:       r_old_cnt <= r_old_cnt;
                endcase
            end
        end
    end

    // magnitudes and signs of the segment terms
    assign w_dx  = (w_key >= w_ax) ? (w_key - w_ax) : (w_ax - w_key);
    assign w_dy  = (w_by >= w_ay) ? (w_by - w_ay) : (w_ay - w_by);
    assign w_den = (w_bx >= w_ax) ? (w_bx - w_ax) : (w_ax - w_bx);
    assign w_neg = (w_key < w_ax) ^ (w_by < w_ay) ^ (w_bx < w_ax);

    // rounded quotient: floor((2*num + den) / (2*den)), one bit per cycle
    assign w_dvd   = {1'b0, r_prod, 1'b0} + DVD_W'(r_den);
    assign w_dv    = {r_den, 1'b0};
    assign w_trial = {r_rem, r_dq[QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, w_dv};
    assign w_ge    = (w_trial >= {1'b0, w_dv});

    assign w_sum = {1'b0, r_y0} + {1'b0, r_dq};
    assign w_dif = {1'b0, r_y0} - {1'b0, r_dq};

    always_comb begin
        if (r_zero_run) begin
            w_res = r_y0;
        end else if (r_neg) begin
            w_res = w_dif[DATA_W] ? '0 : w_dif[DATA_W-1:0];
        end else begin
            w_res = w_sum[DATA_W] ? {DATA_W{1'b1}} : w_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_reading <= i_reading;
        end
        if (i_cmd.mul) begin
            r_prod     <= w_dx * w_dy;
            r_den      <= w_den;
            r_y0       <= w_ay;
            r_neg      <= w_neg;
            r_zero_run <= (w_den == '0);
        end
        if (i_cmd.div_init) begin
            r_rem     <= w_dvd[DATA_W+QUO_W:QUO_W];
            r_dq      <= w_dvd[QUO_W-1:0];
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= w_ge ? w_diff[DATA_W:0] : w_trial[DATA_W:0];
            r_dq      <= {r_dq[QUO_W-2:0], w_ge};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.fin) begin
            if (!i_cmd.sel_new) begin
                r_code <= w_res;
            end else begin
                r_st      <= ST_OK;
                r_seg_res <= SEG_W'(r_seg);
            end
        end else if (i_cmd.miss) begin
            r_st      <= i_cmd.sel_new ? ST_NO_NEW : ST_NO_OLD;
            r_seg_res <= SEG_W'(MAX_POINTS);
            if (!i_cmd.sel_new) begin
                r_code <= NO_CODE;
            end
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_st;
            r_o_code   <= r_code;
            r_o_value  <= r_last;
            r_o_seg    <= r_seg_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_cmd.fin && i_cmd.sel_new) begin
            r_last <= w_res;
        end
    end

    assign o_status      = r_o_status;
    assign o_code_out    = r_o_code;
    assign o_value_out   = r_o_value;
    assign o_segment_end = r_o_seg;

endmodule

// ===== rtl/core/two_table_calibration_remap_unit.sv =====
// Two-table calibration remap: maps a physical reading through an old
// piecewise-linear calibration table to a converter code, then through a
// new table back to a physical value.
// Input channel (i_in_valid / o_in_ready): op 0 and 1 write a point of the
// old or new table in the accepting cycle and give no result; op 2 converts
// i_reading and gives one result; op 3 is dropped.
// Config channel: index 0 old point count, index 1 new point count; always
// ready, to be written only while the unit is idle.
// Output channel (o_out_valid / i_out_ready): status, code, value and the
// end index of the new-table segment used.
// A convert transaction runs from acceptance to result in this order:
// each table is scanned one point per cycle through a single memory read
// port, each interpolation takes a multiply step, a setup step, a
// one-bit-per-cycle divider over 16 quotient bits and a write-back step,
// and the output register is loaded last. A miss in a table ends early.
// Items are taken one at a time; a new item is accepted while the result
// waits, but a convert result waits in its last state until the output
// register is free. Reset sets both counts to 2 and the kept value to 0;
// table contents are undefined until written.
module two_table_calibration_remap_unit #(
    parameter int MAX_POINTS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_op,
    input  logic [ttcr_pkg::IDX_W-1:0]            i_point_index,
    input  logic [ttcr_pkg::DATA_W-1:0]           i_point_code,
    input  logic [ttcr_pkg::DATA_W-1:0]           i_point_value,
    input  logic [ttcr_pkg::DATA_W-1:0]           i_reading,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [1:0]                            o_status,
    output logic [ttcr_pkg::DATA_W-1:0]           o_code_out,
    output logic [ttcr_pkg::DATA_W-1:0]           o_value_out,
    output logic [ttcr_pkg::SEG_W-1:0]            o_segment_end,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ttcr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ttcr_pkg::CNT_W-1:0]            i_cfg_data
);
    import ttcr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ttcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    ttcr_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_point_index (i_point_index),
        .i_point_code  (i_point_code),
        .i_point_value (i_point_value),
        .i_reading     (i_reading),
        .o_status      (o_status),
        .o_code_out    (o_code_out),
        .o_value_out   (o_value_out),
        .o_segment_end (o_segment_end)
    );

endmodule

// ===== sim/two_table_calibration_remap_unit_tb.sv =====
module two_table_calibration_remap_unit_tb;
    import ttcr_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 130;
    localparam int EXP_DEPTH = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] code;
        logic [DATA_W-1:0] value;
        logic [SEG_W-1:0]  seg;
    } t_remap;

    typedef struct {
        logic [1:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] code;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] rd;
        bit                fixed;
        t_remap            res;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_op = '0;
    logic [IDX_W-1:0]     i_point_index = '0;
    logic [DATA_W-1:0]    i_point_code = '0;
    logic [DATA_W-1:0]    i_point_value = '0;
    logic [DATA_W-1:0]    i_reading = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [1:0]           o_status;
    logic [DATA_W-1:0]    o_code_out;
    logic [DATA_W-1:0]    o_value_out;
    logic [SEG_W-1:0]     o_segment_end;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CNT_W-1:0]     i_cfg_data = '0;

    // typed-in expectation travelling with the current input transaction
    bit     fixed_on = 1'b0;
    t_remap fixed_res = '0;

    logic [DATA_W-1:0] old_code [TABLE_DEPTH];
    logic [DATA_W-1:0] old_val [TABLE_DEPTH];
    logic [DATA_W-1:0] new_code [TABLE_DEPTH];
    logic [DATA_W-1:0] new_val [TABLE_DEPTH];
    logic [DATA_W-1:0] kept_value = '0;
    logic [CNT_W-1:0]  old_cnt = 5'd2;
    logic [CNT_W-1:0]  new_cnt = 5'd2;

    t_remap exp_fifo [EXP_DEPTH];
    int     exp_wr = 0;
    int     exp_rd = 0;
    int     err_count = 0;
    int     stall_cycles = 0;
    bit     calm = 1'b0;

    t_stim_row dir_rows [27];

    two_table_calibration_remap_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_point_index (i_point_index),
        .i_point_code  (i_point_code),
        .i_point_value (i_point_value),
        .i_reading     (i_reading),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_code_out    (o_code_out),
        .o_value_out   (o_value_out),
        .o_segment_end (o_segment_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic flag(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic bit brackets(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                                    input logic [DATA_W-1:0] x);
        return (a >= x && x >= b) || (b >= x && x >= a);
    endfunction

    // start + round(delta * rise / run), ties away from zero
    function automatic logic [DATA_W-1:0] lerp(input longint x0, input longint y0,
                                              input longint x1, input longint y1,
                                              input longint x);
        longint den;
        longint num;
        longint an;
        longint ad;
        longint q;
        longint r;
        bit     neg;
        den = x1 - x0;
        if (den == 0) begin
            return y0[DATA_W-1:0];
        end
        num = (x - x0) * (y1 - y0);
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (2 * an + ad) / (2 * ad);
        r = neg ? y0 - q : y0 + q;
        if (r < 0) begin
            r = 0;
        end
        if (r > 65535) begin
            r = 65535;
        end
        return r[DATA_W-1:0];
    endfunction

    task automatic predict_convert(input logic [DATA_W-1:0] rd, output t_remap res);
        int                n;
        bit                hit;
        logic [DATA_W-1:0] code;
        res.status = ST_NO_OLD;
        res.seg = SEG_W'(TABLE_DEPTH);
        code = NO_CODE;
        hit = 1'b0;
        n = (old_cnt > TABLE_DEPTH) ? TABLE_DEPTH : old_cnt;
        for (int i = 1; i < n; i++) begin
            if (!hit && brackets(old_val[i-1], old_val[i], rd)) begin
                code = lerp(old_val[i-1], old_code[i-1], old_val[i], old_code[i], rd);
                hit = 1'b1;
            end
        end
        if (hit) begin
            res.status = ST_NO_NEW;
            hit = 1'b0;
            n = (new_cnt > TABLE_DEPTH) ? TABLE_DEPTH : new_cnt;
            for (int i = 1; i < n; i++) begin
                if (!hit && brackets(new_code[i-1], new_code[i], code)) begin
                    kept_value = lerp(new_code[i-1], new_val[i-1], new_code[i], new_val[i],
                                      code);
                    res.status = ST_OK;
                    res.seg = SEG_W'(i);
                    hit = 1'b1;
                end
            end
        end
        res.code = code;
        res.value = kept_value;
    endtask

    always @(posedge i_clk) begin : monitor
        t_remap res;
        t_remap got;
        bit     moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                if (i_cfg_index == CFG_OLD_COUNT) begin
                    old_cnt = i_cfg_data;
                end else if (i_cfg_index == CFG_NEW_COUNT) begin
                    new_cnt = i_cfg_data;
                end
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                case (i_op)
                    OP_WR_OLD: begin
                        old_code[i_point_index] = i_point_code;
                        old_val[i_point_index] = i_point_value;
                    end
                    OP_WR_NEW: begin
                        new_code[i_point_index] = i_point_code;
                        new_val[i_point_index] = i_point_value;
                    end
                    OP_CONVERT: begin
                        predict_convert(i_reading, res);
                        exp_fifo[exp_wr % EXP_DEPTH] = fixed_on ? fixed_res : res;
                        exp_wr++;
                    end
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                got = '{o_status, o_code_out, o_value_out, o_segment_end};
                if (exp_wr == exp_rd) begin
                    flag($sformatf("unexpected result st=%0d code=%0d value=%0d seg=%0d",
                                   got.status, got.code, got.value, got.seg));
                end else begin
                    res = exp_fifo[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (got.status !== res.status || got.code !== res.code ||
                        got.value !== res.value || got.seg !== res.seg) begin
                        flag($sformatf({"mismatch: exp st=%0d code=%0d value=%0d seg=%0d",
                                        " got st=%0d code=%0d value=%0d seg=%0d"},
                                       res.status, res.code, res.value, res.seg,
                                       got.status, got.code, got.value, got.seg));
                    end
                end
            end
            stall_cycles <= moved ? 0 : stall_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 6);
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit take_gap();
        return !calm && ($urandom_range(99) < 6);
    endfunction

    task automatic put_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] code, input logic [DATA_W-1:0] val,
                            input logic [DATA_W-1:0] rd, input bit fixed,
                            input t_remap res);
        while (take_gap()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_point_index <= idx;
        i_point_code <= code;
        i_point_value <= val;
        i_reading <= rd;
        fixed_on <= fixed;
        fixed_res <= res;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (exp_wr != exp_rd) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [DATA_W-1:0] ramp(input int i);
        int v;
        v = i * 4369 + int'($urandom_range(2000)) - 1000;
        if (i == 0) begin
            v = 0;
        end
        if (i == TABLE_DEPTH - 1) begin
            v = 65535;
        end
        if (v < 0) begin
            v = 0;
        end
        if (v > 65535) begin
            v = 65535;
        end
        return v[DATA_W-1:0];
    endfunction

    // shape 0 rising old values, 1 falling, 2 scattered old codes, 3 scattered old table
    task automatic reload_tables(input int shape);
        logic [DATA_W-1:0] oc;
        logic [DATA_W-1:0] ov;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            ov = ramp(i);
            oc = ramp(i);
            if (shape == 1) begin
                ov = 16'hFFFF - ov;
            end
            if (shape >= 2) begin
                oc = 16'($urandom);
            end
            if (shape == 3) begin
                ov = 16'($urandom);
            end
            put_item(OP_WR_OLD, IDX_W'(i), oc, ov, 16'($urandom), 1'b0, '0);
            put_item(OP_WR_NEW, IDX_W'(i), ramp(i), 16'($urandom), 16'($urandom), 1'b0, '0);
        end
    endtask

    task automatic random_item(output bit counted);
        int                pick;
        int                n;
        int                seg;
        logic [1:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] code;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] rd;
        pick = $urandom_range(99);
        idx = IDX_W'($urandom);
        code = 16'($urandom);
        val = 16'($urandom);
        rd = 16'($urandom);
        n = (old_cnt > TABLE_DEPTH) ? TABLE_DEPTH : old_cnt;
        if (pick < 14) begin
            op = OP_WR_OLD;
            if ($urandom_range(99) < 70) begin
                code = old_code[idx] + 16'($urandom_range(255)) - 16'd128;
                val = old_val[idx] + 16'($urandom_range(255)) - 16'd128;
            end
        end else if (pick < 28) begin
            op = OP_WR_NEW;
            if ($urandom_range(99) < 70) begin
                code = new_code[idx] + 16'($urandom_range(255)) - 16'd128;
                val = new_val[idx] + 16'($urandom_range(255)) - 16'd128;
            end
        end else if (pick < 33) begin
            op = OP_UNUSED;
        end else begin
            op = OP_CONVERT;
            pick = $urandom_range(99);
            if (n >= 2 && pick < 55) begin
                seg = $urandom_range(n - 1, 1);
                rd = 16'($urandom_range(old_val[seg-1], old_val[seg]));
            end else if (n >= 1 && pick < 75) begin
                rd = old_val[$urandom_range(n - 1)];
            end
        end
        counted = (op != OP_UNUSED);
        put_item(op, idx, code, val, rd, 1'b0, '0);
    endtask

    initial begin : stimulus
        int  old_sets [PHASES];
        int  new_sets [PHASES];
        int  done_items;
        bit  counted;
        old_sets = '{16, 0, 1, 31, 16, 5, 17, 2, 0, 0};
        new_sets = '{16, 16, 16, 3, 0, 1, 31, 16, 0, 0};
        dir_rows = '{
            '{OP_UNUSED,  4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
            '{OP_WR_OLD,  4'd0,  16'd100,  16'd0,    16'd0,    1'b0, '0},
            '{OP_WR_OLD,  4'd1,  16'd200,  16'd1000, 16'd0,    1'b0, '0},
            '{OP_WR_NEW,  4'd0,  16'd100,  16'd5000, 16'd0,    1'b0, '0},
            '{OP_WR_NEW,  4'd1,  16'd200,  16'd6000, 16'd0,    1'b0, '0},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'd0,    1'b1,
              '{ST_OK, 16'd100, 16'd5000, 5'd1}},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'd1000, 1'b1,
              '{ST_OK, 16'd200, 16'd6000, 5'd1}},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'd500,  1'b1,
              '{ST_OK, 16'd150, 16'd5500, 5'd1}},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'hFFFF, 1'b1,
              '{ST_NO_OLD, NO_CODE, 16'd5500, 5'd16}},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'd5,    1'b0, '0},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'd999,  1'b0, '0},
            '{OP_WR_OLD,  4'd0,  16'd0,    16'hFFFF, 16'd0,    1'b0, '0},
            '{OP_WR_OLD,  4'd1,  16'hFFFF, 16'd0,    16'd0,    1'b0, '0},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'hFFFF, 1'b0, '0},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'd0,    1'b0, '0},
            '{OP_WR_NEW,  4'd0,  16'd0,    16'hFFFF, 16'd0,    1'b0, '0},
            '{OP_WR_NEW,  4'd1,  16'hFFFF, 16'd0,    16'd0,    1'b0, '0},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'hFFFF, 1'b1,
              '{ST_OK, 16'd0, 16'hFFFF, 5'd1}},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'd0,    1'b1,
              '{ST_OK, 16'hFFFF, 16'd0, 5'd1}},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'd32768, 1'b0, '0},
            '{OP_WR_OLD,  4'd0,  16'd7,    16'd300,  16'd0,    1'b0, '0},
            '{OP_WR_OLD,  4'd1,  16'd9,    16'd300,  16'd0,    1'b0, '0},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'd300,  1'b0, '0},
            '{OP_WR_NEW,  4'd0,  16'd7,    16'd40000, 16'd0,   1'b0, '0},
            '{OP_WR_NEW,  4'd1,  16'd7,    16'd2,    16'd0,    1'b0, '0},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'd300,  1'b1,
              '{ST_OK, 16'd7, 16'd40000, 5'd1}},
            '{OP_CONVERT, 4'd0,  16'd0,    16'd0,    16'd301,  1'b1,
              '{ST_NO_OLD, NO_CODE, 16'd40000, 5'd16}}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            put_item(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].code, dir_rows[r].val,
                     dir_rows[r].rd, dir_rows[r].fixed, dir_rows[r].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            calm = (p == 4);
            if (p >= 8) begin
                old_sets[p] = $urandom_range(31);
                new_sets[p] = $urandom_range(31);
            end
            write_reg(CFG_OLD_COUNT, CNT_W'(old_sets[p]));
            write_reg(CFG_NEW_COUNT, CNT_W'(new_sets[p]));
            if (p == 1 || p == 5) begin
                write_reg(CFG_SPARE_A, CNT_W'($urandom));
                write_reg(CFG_SPARE_B, CNT_W'($urandom));
            end
            i_cfg_valid <= 1'b0;
            reload_tables(p % 4);
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                random_item(counted);
                if (counted) begin
                    done_items++;
                end
            end
        end

        wait_idle();
        if (exp_wr != exp_rd) begin
            flag($sformatf("%0d results never arrived", exp_wr - exp_rd));
        end
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
